>>> src/afrc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// afrc_pkg
// Types and character codes shared by the ASCII frame receiver.
// ----------------------------------------------------------------------------
package afrc_pkg;

    typedef logic [1:0]  t_op;
    typedef logic [7:0]  t_byte;
    typedef logic [6:0]  t_index;
    typedef logic [3:0]  t_status;
    typedef logic [11:0] t_sum;

    // operations
    localparam t_op OP_BYTE    = 2'd0;
    localparam t_op OP_READ    = 2'd1;
    localparam t_op OP_RELEASE = 2'd2;

    // result status codes
    localparam t_status ST_HUNTING  = 4'd0;
    localparam t_status ST_HEADER   = 4'd1;
    localparam t_status ST_STORED   = 4'd2;
    localparam t_status ST_VALID    = 4'd3;
    localparam t_status ST_BAD_SUM  = 4'd4;
    localparam t_status ST_OVERRUN  = 4'd5;
    localparam t_status ST_DROPPED  = 4'd6;
    localparam t_status ST_READ     = 4'd7;
    localparam t_status ST_RELEASED = 4'd8;

    // characters
    localparam t_byte CH_HASH = 8'h23;
    localparam t_byte CH_LB   = 8'h62;
    localparam t_byte CH_LC   = 8'h63;
    localparam t_byte CH_V    = 8'h56;
    localparam t_byte CH_O    = 8'h4F;
    localparam t_byte CH_Q    = 8'h51;
    localparam t_byte CH_C    = 8'h43;
    localparam t_byte CH_CR   = 8'h0D;
    localparam t_byte CH_EQ   = 8'h3D;

    // first stored entry past the three header bytes
    localparam int unsigned HDR_LEN = 3;

endpackage

`default_nettype wire

>>> src/afrc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// afrc_if
// Valid/ready channels for the frame receiver: request and result.
// ----------------------------------------------------------------------------
interface afrc_in_if;
    import afrc_pkg::*;

    logic   valid;
    logic   ready;
    t_op    op;
    t_byte  rx_byte;
    t_index read_index;

    modport source (output valid, output op, output rx_byte, output read_index,
                    input ready);
    modport sink   (input valid, input op, input rx_byte, input read_index,
                    output ready);
endinterface

interface afrc_out_if;
    import afrc_pkg::*;

    logic    valid;
    logic    ready;
    t_status status;
    t_byte   frame_length;
    t_byte   read_data;
    logic    locked;

    modport source (output valid, output status, output frame_length,
                    output read_data, output locked, input ready);
    modport sink   (input valid, input status, input frame_length,
                    input read_data, input locked, output ready);
endinterface

`default_nettype wire

>>> src/afrc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// afrc_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module afrc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> src/ascii_frame_receiver_checksum.sv
// A request is registered with the store read in stage 1, then in the output
// register, which presents the result. Throughput: one transaction per cycle
// while the result side is ready; the per-byte update is a single pass
// between the request and the frame-store read register. Reset (synchronous,
// active low) clears the hunt/frame/lock state and the pipeline valids. Frame
// store contents stay undefined until written; there is no clearing pass.
`default_nettype none
// ----------------------------------------------------------------------------
// ascii_frame_receiver_checksum
// Hunts for '#', 'b'/'c', kind-letter headers, stores the frame up to CR and
// checks the two-character additive checksum before locking the store.
// ----------------------------------------------------------------------------
module ascii_frame_receiver_checksum #(
    parameter int unsigned BUFFER_DEPTH = 128
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    afrc_in_if.sink     i_in,
    afrc_out_if.source  o_out
);
    import afrc_pkg::*;

    localparam int unsigned AW = $clog2(BUFFER_DEPTH);
    localparam logic [7:0]  DEPTH_C = 8'(BUFFER_DEPTH);
    localparam logic [7:0]  HDR_C   = 8'(HDR_LEN);

    // frame state
    logic [7:0] r_wp,       n_wp;
    logic       r_in_frame, n_in_frame;
    t_byte      r_prev1,    n_prev1;
    t_byte      r_prev2,    n_prev2;
    t_sum       r_sum,      n_sum;
    logic       r_lock,     n_lock;
    t_byte      r_len,      n_len;
    // shadow of the last two stored bytes and of header entries one and two
    t_byte      r_last1,    n_last1;
    t_byte      r_last2,    n_last2;
    t_byte      r_ent1,     n_ent1;
    t_byte      r_ent2,     n_ent2;

    // stage 1: waits for the store read
    logic       r_s1_valid;
    t_status    r_s1_status;
    t_byte      r_s1_len;
    logic       r_s1_locked;
    logic       r_s1_use_ram;
    t_byte      r_s1_data;

    // output register
    logic       r_o_valid;
    t_status    r_o_status;
    t_byte      r_o_len;
    t_byte      r_o_data;
    logic       r_o_locked;

    logic       w_acc;
    logic       w_s1_adv;
    t_status    w_status;
    t_byte      w_data;
    logic       w_use_ram;
    logic       w_we;
    t_byte      w_wdata;
    t_byte      w_rdata;
    logic       w_header;
    logic       w_kind;
    t_sum       w_chk;
    t_byte      w_want_hi;
    t_byte      w_want_lo;
    logic [7:0] w_idx;

    assign w_s1_adv   = r_s1_valid && (!r_o_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || w_s1_adv;
    assign w_acc      = i_in.valid && i_in.ready;

    assign w_idx  = {1'b0, i_in.read_index};
    assign w_kind = (i_in.rx_byte == CH_V) || (i_in.rx_byte == CH_O) ||
                    (i_in.rx_byte == CH_Q) || (i_in.rx_byte == CH_C);
    assign w_header = (r_prev2 == CH_HASH) &&
                      ((r_prev1 == CH_LB) || (r_prev1 == CH_LC)) && w_kind;

    // sum with the two checksum characters taken back out
    assign w_chk     = r_sum - {4'd0, r_last2} - {4'd0, r_last1};
    assign w_want_hi = CH_EQ + {2'd0, w_chk[11:6]};
    assign w_want_lo = CH_EQ + {2'd0, w_chk[5:0]};

    always_comb begin
        n_wp       = r_wp;
        n_in_frame = r_in_frame;
        n_prev1    = r_prev1;
        n_prev2    = r_prev2;
        n_sum      = r_sum;
        n_lock     = r_lock;
        n_len      = r_len;
        n_last1    = r_last1;
        n_last2    = r_last2;
        n_ent1     = r_ent1;
        n_ent2     = r_ent2;
        w_status   = ST_HUNTING;
        w_data     = '0;
        w_use_ram  = 1'b0;
        w_we       = 1'b0;
        w_wdata    = i_in.rx_byte;
        case (i_in.op)
            OP_BYTE: begin
                if (r_lock) begin
                    w_status = ST_DROPPED;
                end else if (!r_in_frame) begin
                    if (w_header) begin
                        n_ent1     = r_prev1;
                        n_ent2     = i_in.rx_byte;
                        n_last2    = r_prev1;
                        n_last1    = i_in.rx_byte;
                        n_wp       = HDR_C;
                        n_sum      = {4'd0, r_prev2} + {4'd0, r_prev1} +
                                     {4'd0, i_in.rx_byte};
                        n_prev1    = '0;
                        n_prev2    = '0;
                        n_in_frame = 1'b1;
                        w_status   = ST_HEADER;
                    end else begin
                        n_prev2 = r_prev1;
                        n_prev1 = i_in.rx_byte;
                    end
                end else if (r_wp >= DEPTH_C) begin
                    n_wp       = '0;
                    n_in_frame = 1'b0;
                    n_lock     = 1'b0;
                    w_status   = ST_OVERRUN;
                end else if (i_in.rx_byte != CH_CR) begin
                    w_we     = 1'b1;
                    n_wp     = r_wp + 8'd1;
                    n_sum    = r_sum + {4'd0, i_in.rx_byte};
                    n_last2  = r_last1;
                    n_last1  = i_in.rx_byte;
                    w_status = ST_STORED;
                end else begin
                    n_sum = w_chk;
                    if ((w_want_hi == r_last2) && (w_want_lo == r_last1)) begin
                        w_we     = 1'b1;
                        w_wdata  = CH_CR;
                        n_len    = r_wp + 8'd1;
                        n_lock   = 1'b1;
                        w_status = ST_VALID;
                    end else begin
                        n_lock   = 1'b0;
                        w_status = ST_BAD_SUM;
                    end
                    n_wp       = '0;
                    n_in_frame = 1'b0;
                end
            end
            OP_READ: begin
                w_status = ST_READ;
                if (w_idx < DEPTH_C) begin
                    // header entries live in registers (the hash is a constant), the rest in the RAM
                    if (w_idx == 8'd0) begin
                        w_data = CH_HASH;
                    end else if (w_idx == 8'd1) begin
                        w_data = r_ent1;
                    end else if (w_idx == 8'd2) begin
                        w_data = r_ent2;
                    end else begin
                        w_use_ram = 1'b1;
                    end
                end
            end
            OP_RELEASE: begin
                n_lock   = 1'b0;
                w_status = ST_RELEASED;
            end
            default: begin
            end
        endcase
    end

    afrc_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_acc && w_we),
        .i_waddr (r_wp[AW-1:0]),
        .i_wdata (w_wdata),
        .i_re    (w_acc),
        .i_raddr (w_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp       <= '0;
            r_in_frame <= 1'b0;
            r_prev1    <= '0;
            r_prev2    <= '0;
            r_sum      <= '0;
            r_lock     <= 1'b0;
            r_len      <= '0;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (w_acc) begin
                r_wp       <= n_wp;
                r_in_frame <= n_in_frame;
                r_prev1    <= n_prev1;
                r_prev2    <= n_prev2;
                r_sum      <= n_sum;
                r_lock     <= n_lock;
                r_len      <= n_len;
            end
            if (w_acc) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_adv) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_last1      <= n_last1;
            r_last2      <= n_last2;
            r_ent1       <= n_ent1;
            r_ent2       <= n_ent2;
            r_s1_status  <= w_status;
            r_s1_len     <= n_len;
            r_s1_locked  <= n_lock;
            r_s1_use_ram <= w_use_ram;
            r_s1_data    <= w_data;
        end
        if (w_s1_adv) begin
            r_o_status <= r_s1_status;
            r_o_len    <= r_s1_len;
            r_o_locked <= r_s1_locked;
            r_o_data   <= r_s1_use_ram ? w_rdata : r_s1_data;
        end
    end

    assign o_out.valid        = r_o_valid;
    assign o_out.status       = r_o_status;
    assign o_out.frame_length = r_o_len;
    assign o_out.read_data    = r_o_data;
    assign o_out.locked       = r_o_locked;

`ifndef SYNTHESIS
    a_wp_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_frame |-> (r_wp >= HDR_C) && (r_wp <= DEPTH_C))
        else $error("write pointer out of range inside a frame");

    a_wp_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_frame |-> (r_wp == 8'd0))
        else $error("write pointer not cleared outside a frame");

    a_lock_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lock |-> !r_in_frame)
        else $error("store locked while a frame is being received");

    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_in.op == OP_BYTE) && r_lock) |=>
            (r_s1_status == ST_DROPPED) && r_lock && $stable(r_wp))
        else $error("byte while locked not dropped");

    a_valid_locks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && (r_o_status == ST_VALID)) |-> r_o_locked)
        else $error("valid frame reported without lock");
`endif

endmodule

`default_nettype wire

>>> tb/sv/ascii_frame_receiver_checksum_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ascii_frame_receiver_checksum_test
// Drives byte, read and release requests into the frame receiver, predicts
// every result from a cycle-free model of the hunt/store/checksum/lock logic,
// and compares the results field by field. The stimulus covers short and
// full-length frames, checksum failures, overruns and random traffic, with
// random idling on both channels and one long stall at the result side.
// ----------------------------------------------------------------------------
module ascii_frame_receiver_checksum_test;
    import afrc_pkg::*;

    localparam int unsigned BUF_DEPTH    = 128;
    localparam int unsigned RANDOM_ITEMS = 190;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned STALL_CYCLES = 80;
    localparam t_op         OP_UNUSED    = 2'd3;

    typedef enum int {IDLE_NONE, IDLE_SHORT, IDLE_WIDE} idle_mode_e;

    typedef struct packed {
        t_status status;
        t_byte   frame_length;
        t_byte   read_data;
        logic    locked;
    } frame_result_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    afrc_in_if  byte_ch ();
    afrc_out_if res_ch ();

    ascii_frame_receiver_checksum #(
        .BUFFER_DEPTH(BUF_DEPTH)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (byte_ch),
        .o_out  (res_ch)
    );

    always #1 i_clk = ~i_clk;

    // predicted receiver state
    t_byte       rx_store [BUF_DEPTH];
    bit          rx_written [BUF_DEPTH];
    int unsigned rx_written_count = 0;
    int unsigned rx_wptr = 0;
    bit          rx_in_frame = 1'b0;
    t_byte       rx_hist_one = '0;
    t_byte       rx_hist_two = '0;
    t_sum        rx_sum = '0;
    bit          rx_locked = 1'b0;
    t_byte       rx_last_len = '0;

    frame_result_t pending_results [$];

    int unsigned items_sent = 0;
    int unsigned results_checked = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    int unsigned status_seen [9];
    int unsigned hold_req = 0;
    idle_mode_e  sender_mode = IDLE_SHORT;
    idle_mode_e  sink_mode = IDLE_SHORT;

    function automatic int unsigned draw_gap(input idle_mode_e mode);
        case (mode)
            IDLE_NONE:  return 0;
            IDLE_SHORT: return $urandom_range(0, 3);
            default:    return $urandom_range(0, 19);
        endcase
    endfunction

    function automatic t_byte pick_kind();
        case ($urandom_range(0, 3))
            0:       return CH_V;
            1:       return CH_O;
            2:       return CH_Q;
            default: return CH_C;
        endcase
    endfunction

    // bytes that matter to the header hunt, mixed with plain noise
    function automatic t_byte pick_frame_char();
        case ($urandom_range(0, 7))
            0:       return CH_HASH;
            1:       return CH_LB;
            2:       return CH_LC;
            3:       return pick_kind();
            4:       return CH_CR;
            5:       return CH_EQ;
            default: return t_byte'($urandom);
        endcase
    endfunction

    // advances the predicted state by one request and returns its result
    function automatic frame_result_t predict_step(input t_op op, input t_byte b,
                                                   input t_index idx);
        frame_result_t r;
        t_byte         hi;
        t_byte         lo;
        t_sum          s;
        r = '0;
        r.status = ST_HUNTING;
        if (op == OP_BYTE) begin
            if (rx_locked) begin
                r.status = ST_DROPPED;
            end else if (!rx_in_frame) begin
                if (rx_hist_two == CH_HASH && (rx_hist_one == CH_LB || rx_hist_one == CH_LC)
                    && (b == CH_V || b == CH_O || b == CH_Q || b == CH_C)) begin
                    rx_store[0] = rx_hist_two;
                    rx_store[1] = rx_hist_one;
                    rx_store[2] = b;
                    for (int k = 0; k < 3; k++) begin
                        if (!rx_written[k]) rx_written_count++;
                        rx_written[k] = 1'b1;
                    end
                    rx_wptr = HDR_LEN;
                    rx_sum = t_sum'(rx_hist_two) + t_sum'(rx_hist_one) + t_sum'(b);
                    rx_hist_two = '0;
                    rx_hist_one = '0;
                    rx_in_frame = 1'b1;
                    r.status = ST_HEADER;
                end else begin
                    rx_hist_two = rx_hist_one;
                    rx_hist_one = b;
                end
            end else if (rx_wptr >= BUF_DEPTH) begin
                // store full: byte lost, frame dropped, even on a CR
                rx_wptr = 0;
                rx_in_frame = 1'b0;
                rx_locked = 1'b0;
                r.status = ST_OVERRUN;
            end else if (b != CH_CR) begin
                rx_store[rx_wptr] = b;
                if (!rx_written[rx_wptr]) rx_written_count++;
                rx_written[rx_wptr] = 1'b1;
                rx_wptr++;
                rx_sum = rx_sum + t_sum'(b);
                r.status = ST_STORED;
            end else begin
                // last two stored bytes are the checksum, not part of the sum
                hi = rx_store[rx_wptr - 2];
                lo = rx_store[rx_wptr - 1];
                s = rx_sum - t_sum'(hi) - t_sum'(lo);
                rx_sum = s;
                if (hi == CH_EQ + t_byte'(s[11:6]) && lo == CH_EQ + t_byte'(s[5:0])) begin
                    rx_store[rx_wptr] = CH_CR;
                    if (!rx_written[rx_wptr]) rx_written_count++;
                    rx_written[rx_wptr] = 1'b1;
                    rx_last_len = t_byte'(rx_wptr + 1);
                    rx_locked = 1'b1;
                    r.status = ST_VALID;
                end else begin
                    rx_locked = 1'b0;
                    r.status = ST_BAD_SUM;
                end
                rx_wptr = 0;
                rx_in_frame = 1'b0;
            end
        end else if (op == OP_READ) begin
            r.read_data = rx_store[idx];
            r.status = ST_READ;
        end else if (op == OP_RELEASE) begin
            rx_locked = 1'b0;
            r.status = ST_RELEASED;
        end
        r.frame_length = rx_last_len;
        r.locked = rx_locked;
        status_seen[r.status]++;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("result %0d: %s got %0d, expected %0d", results_checked, what, got, want);
        mismatches++;
    endtask

    // one request: optional idle gap, then hold it until the handshake
    task automatic send_item(input t_op op, input t_byte b, input t_index idx);
        int unsigned   gap;
        frame_result_t want;
        gap = draw_gap(sender_mode);
        repeat (gap) begin
            @(negedge i_clk);
            byte_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        byte_ch.valid      <= 1'b1;
        byte_ch.op         <= op;
        byte_ch.rx_byte    <= b;
        byte_ch.read_index <= idx;
        do @(posedge i_clk); while (byte_ch.ready !== 1'b1);
        want = predict_step(op, b, idx);
        pending_results.push_back(want);
        if (op != OP_UNUSED && want.status != ST_DROPPED) items_sent++;
    endtask

    // reads only entries that some frame has already written
    task automatic send_read();
        t_index idx;
        if (rx_written_count == 0) return;
        do idx = t_index'($urandom_range(0, BUF_DEPTH - 1)); while (!rx_written[idx]);
        send_item(OP_READ, t_byte'($urandom), idx);
    endtask

    task automatic send_frame(input t_byte second, input t_byte kind,
                              input int unsigned payload_len, input bit corrupt);
        t_byte       frame_bytes [$];
        t_byte       b;
        t_sum        s;
        int unsigned pos;
        frame_bytes = {CH_HASH, second, kind};
        repeat (payload_len) begin
            do b = t_byte'($urandom); while (b == CH_CR);
            frame_bytes.push_back(b);
        end
        s = '0;
        foreach (frame_bytes[k]) s = s + t_sum'(frame_bytes[k]);
        frame_bytes.push_back(CH_EQ + t_byte'(s[11:6]));
        frame_bytes.push_back(CH_EQ + t_byte'(s[5:0]));
        if (corrupt) begin
            pos = frame_bytes.size() - 1 - $urandom_range(0, 1);
            frame_bytes[pos] = frame_bytes[pos] + 8'd1;
        end
        frame_bytes.push_back(CH_CR);
        foreach (frame_bytes[k]) send_item(OP_BYTE, frame_bytes[k], t_index'($urandom));
    endtask

    task automatic test_directed_basics();
        sender_mode = IDLE_SHORT;
        sink_mode = IDLE_SHORT;
        send_item(OP_UNUSED, 8'hFF, 7'h7F);
        send_item(OP_RELEASE, 8'h00, 7'h00);
        send_item(OP_BYTE, 8'h00, 7'h7F);
        send_item(OP_BYTE, 8'hFF, 7'h00);
        // false start: hash and 'b' followed by a letter that is no frame kind
        send_item(OP_BYTE, CH_HASH, 7'h00);
        send_item(OP_BYTE, CH_LB, 7'h00);
        send_item(OP_BYTE, CH_EQ, 7'h00);
        send_frame(CH_LB, CH_V, 0, 1'b0);
        send_item(OP_READ, 8'h00, 7'd0);
        send_item(OP_READ, 8'hFF, 7'd5);
        send_item(OP_BYTE, CH_HASH, 7'h00);
        send_item(OP_RELEASE, 8'h00, 7'h00);
        send_frame(CH_LC, CH_O, 1, 1'b1);
        send_frame(CH_LC, CH_Q, 2, 1'b0);
        send_item(OP_RELEASE, 8'h00, 7'h00);
        send_frame(CH_LB, CH_C, 1, 1'b0);
        send_item(OP_RELEASE, 8'h00, 7'h00);
    endtask

    task automatic test_length_extremes();
        sender_mode = IDLE_SHORT;
        sink_mode = IDLE_SHORT;
        // longest valid frame fills every entry, CR in the last one
        send_frame(CH_LC, CH_V, BUF_DEPTH - 6, 1'b0);
        send_item(OP_READ, 8'h00, t_index'(BUF_DEPTH - 1));
        send_item(OP_READ, 8'hFF, 7'd0);
        send_item(OP_RELEASE, 8'h00, 7'h00);
        // store full when the CR arrives
        send_frame(CH_LB, CH_O, BUF_DEPTH - 5, 1'b0);
        // store full on the second checksum character
        send_frame(CH_LC, CH_Q, BUF_DEPTH - 4, 1'b0);
    endtask

    task automatic test_backpressure();
        sender_mode = IDLE_NONE;
        hold_req = STALL_CYCLES;
        send_frame(CH_LB, CH_Q, 24, 1'b0);
        send_read();
        send_item(OP_RELEASE, 8'h00, 7'h00);
        sender_mode = IDLE_SHORT;
    endtask

    task automatic test_random_traffic();
        int unsigned start_count;
        int unsigned scenario;
        int unsigned choice;
        int unsigned n;
        start_count = items_sent;
        scenario = 0;
        while (items_sent < start_count + RANDOM_ITEMS) begin
            if (scenario % 30 == 0) begin
                sender_mode = idle_mode_e'($urandom_range(0, 2));
                sink_mode = idle_mode_e'($urandom_range(0, 2));
            end
            scenario++;
            choice = $urandom_range(0, 99);
            if (choice < 50) begin
                // clear the way so the frame is seen from its own header
                if (rx_in_frame) send_item(OP_BYTE, CH_CR, t_index'($urandom));
                if (rx_locked && $urandom_range(0, 3) != 0)
                    send_item(OP_RELEASE, t_byte'($urandom), t_index'($urandom));
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
                send_frame($urandom_range(0, 1) ? CH_LB : CH_LC, pick_kind(), n,
                           $urandom_range(0, 4) == 0);
                if (rx_locked) begin
                    repeat ($urandom_range(0, 3)) send_read();
                    if ($urandom_range(0, 2) == 0)
                        send_item(OP_BYTE, pick_frame_char(), t_index'($urandom));
                    if ($urandom_range(0, 6) != 0)
                        send_item(OP_RELEASE, t_byte'($urandom), t_index'($urandom));
                end
            end else if (choice < 65) begin
                repeat ($urandom_range(1, 6))
                    send_item(OP_BYTE, pick_frame_char(), t_index'($urandom));
            end else if (choice < 75) begin
                send_item(OP_BYTE, CH_HASH, t_index'($urandom));
                if ($urandom_range(0, 2) != 0)
                    send_item(OP_BYTE, $urandom_range(0, 1) ? CH_LB : CH_LC, t_index'($urandom));
                send_item(OP_BYTE, pick_frame_char(), t_index'($urandom));
            end else if (choice < 88) begin
                repeat ($urandom_range(1, 3)) send_read();
            end else if (choice < 96) begin
                send_item(OP_RELEASE, t_byte'($urandom), t_index'($urandom));
            end else begin
                send_item(OP_UNUSED, t_byte'($urandom), t_index'($urandom));
            end
        end
    endtask

    // result side: random hold-offs, or one long stall when asked for
    initial begin : result_sink
        int unsigned wait_cycles;
        res_ch.ready = 1'b0;
        forever begin
            if (hold_req != 0) begin
                wait_cycles = hold_req;
                hold_req = 0;
            end else begin
                wait_cycles = draw_gap(sink_mode);
            end
            repeat (wait_cycles) begin
                @(negedge i_clk);
                res_ch.ready <= 1'b0;
            end
            @(negedge i_clk);
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (res_ch.valid !== 1'b1);
        end
    end

    always @(posedge i_clk) begin : result_check
        frame_result_t want;
        if (i_rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing expected, status", res_ch.status, 0);
            end else begin
                want = pending_results.pop_front();
                if (res_ch.status !== want.status)
                    report_mismatch("status", res_ch.status, want.status);
                if (res_ch.frame_length !== want.frame_length)
                    report_mismatch("frame_length", res_ch.frame_length, want.frame_length);
                if (res_ch.read_data !== want.read_data)
                    report_mismatch("read_data", res_ch.read_data, want.read_data);
                if (res_ch.locked !== want.locked)
                    report_mismatch("locked", res_ch.locked, want.locked);
                results_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timed out after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("ascii_frame_receiver_checksum_test failed");
            $finish;
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        byte_ch.valid      = 1'b0;
        byte_ch.op         = OP_BYTE;
        byte_ch.rx_byte    = '0;
        byte_ch.read_index = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_basics();
        test_length_extremes();
        test_backpressure();
        test_random_traffic();

        @(negedge i_clk);
        byte_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d requests counted, %0d results checked over %0d cycles",
                 items_sent, results_checked, cycle_count);
        $display("frames: %0d valid, %0d bad checksum, %0d overrun, %0d bytes dropped locked",
                 status_seen[ST_VALID], status_seen[ST_BAD_SUM], status_seen[ST_OVERRUN],
                 status_seen[ST_DROPPED]);
        if (mismatches == 0) begin
            $display("ascii_frame_receiver_checksum_test passed");
        end else begin
            $display("ascii_frame_receiver_checksum_test failed");
        end
        $finish;
    end

endmodule
